// ----- src/tqps_pkg.sv -----
// shared types, constants and helpers of the textured quad pixel shader
package tqps_pkg;

	localparam int CoordW = 13;
	localparam int TexelW = 4;
	localparam int TexAddrW = 8;
	localparam int TexDepth = 256;
	localparam int FracBits = 16;
	localparam int InvW = 32;
	localparam int EdgeW = 28;
	localparam int AreaW = 28;
	localparam int DivCntW = 6;
	localparam int RegIdxW = 3;
	localparam int TexWDef = 16;
	localparam int TexHDef = 16;
	localparam int DstWDef = 160;
	localparam int DstHDef = 120;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_SHADE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		REG_C0X = 3'd0,
		REG_C0Y = 3'd1,
		REG_C1X = 3'd2,
		REG_C1Y = 3'd3,
		REG_C2X = 3'd4,
		REG_C2Y = 3'd5,
		REG_C3X = 3'd6,
		REG_C3Y = 3'd7
	} reg_idx_t;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [EdgeW-1:0] edge_t;
	typedef logic signed [InvW-1:0] inv_t;

	typedef struct packed {
		logic       busy;
		logic       done;
	} div_status_t;

	// edge function of a->b at p, exact on 13-bit coordinates
	function automatic edge_t edge_fn(coord_t ax, coord_t ay, coord_t bx, coord_t by,
		coord_t px, coord_t py);
		logic signed [CoordW:0] dy, dx, qx, qy;
		logic signed [2*CoordW+1:0] p0, p1;
		begin
			dy = {by[CoordW-1], by} - {ay[CoordW-1], ay};
			dx = {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
			qx = {px[CoordW-1], px} - {ax[CoordW-1], ax};
			qy = {py[CoordW-1], py} - {ay[CoordW-1], ay};
			p0 = dy * qx;
			p1 = dx * qy;
			edge_fn = EdgeW'(p0 - p1);
		end
	endfunction

	function automatic logic top_left(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		top_left = (ay < by) || (ay == by && ax < bx);
	endfunction

endpackage

// ----- src/tqps_stream_if.sv -----
// valid/ready channel carrying one packed payload
interface tqps_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/textured_quad_pixel_shader_core.sv -----
// top level: quad pixel shader with texture ram and three-stage pixel pipe
//
// channel  dir  fields
// in_ch    in   opcode, texel_index, texel_value, pixel_x, pixel_y
// out_ch   out  write_enable, dest_x, dest_y, color
// cfg      in   cfg_we, cfg_idx, cfg_data (corner registers)
//
// one item per cycle unless the output or a divide stalls; an input beat passes
// stages 1, 2 and 3 to the result register. stage 1 computes edges, stage 2 weights
// (one 28x32 multiply each), stage 3 is the texture ram read. a corner write starts
// two inverse-area divides; input stalls from the write until both finish
// reset clears control and corner registers; texture ram holds no valid state
// the pipe advances when the output register is empty or taken
module textured_quad_pixel_shader_core #(
	parameter int TEX_W = tqps_pkg::TexWDef,
	parameter int TEX_H = tqps_pkg::TexHDef,
	parameter int DST_W = tqps_pkg::DstWDef,
	parameter int DST_H = tqps_pkg::DstHDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tqps_stream_if.sink                   in_ch,
	tqps_stream_if.source                 out_ch,
	input  logic                          cfg_we,
	input  logic [tqps_pkg::RegIdxW-1:0]  cfg_idx,
	input  logic [tqps_pkg::CoordW-1:0]   cfg_data
);
	import tqps_pkg::*;

	// in_ch.data = {opcode, texel_index, texel_value, pixel_x, pixel_y}
	// out_ch.data = {write_enable, dest_x, dest_y, color}
	localparam int MulW = EdgeW + InvW;

	coord_t cx_q [4];
	coord_t cy_q [4];
	inv_t inv1, inv2;
	div_status_t st1, st2;
	logic div_start_q;
	logic signed [AreaW-1:0] area1, area2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
			end
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= cfg_we;
			if (cfg_we) begin
				if (cfg_idx[0]) cy_q[cfg_idx[2:1]] <= cfg_data;
				else cx_q[cfg_idx[2:1]] <= cfg_data;
			end
		end
	end

	assign area1 = edge_fn(cx_q[0], cy_q[0], cx_q[3], cy_q[3], cx_q[2], cy_q[2]);
	assign area2 = edge_fn(cx_q[2], cy_q[2], cx_q[1], cy_q[1], cx_q[0], cy_q[0]);

	tqps_inv_div u_div1 (.clk, .arst_n, .start(div_start_q), .area(area1),
		.inv(inv1), .status(st1));
	tqps_inv_div u_div2 (.clk, .arst_n, .start(div_start_q), .area(area2),
		.inv(inv2), .status(st2));

	// pipeline control; no beat is taken while the inverse areas are stale
	logic v1_s1, v2_s2, v3_s3, adv, div_busy, in_acc;
	assign adv = !v3_s3 || out_ch.ready;
	assign div_busy = cfg_we || st1.busy || st2.busy;
	assign in_ch.ready = adv && !div_busy;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = v3_s3;

	logic       op_in;
	logic [TexAddrW-1:0] tidx_in;
	logic [TexelW-1:0] tval_in;
	coord_t px_in, py_in;
	assign {op_in, tidx_in, tval_in, px_in, py_in} = in_ch.data;

	// bounding limits
	coord_t maxx, maxy;
	always_comb begin
		maxx = cx_q[0];
		maxy = cy_q[0];
		for (int i = 1; i < 4; i++) begin
			if (cx_q[i] > maxx) maxx = cx_q[i];
			if (cy_q[i] > maxy) maxy = cy_q[i];
		end
		if (maxx > CoordW'(DST_W)) maxx = CoordW'(DST_W);
		if (maxy > CoordW'(DST_H)) maxy = CoordW'(DST_H);
	end

	// stage 1: edges and inside tests
	edge_t e03, e32, e20, e21, e10, e02;
	logic in1, in2, keep;
	always_comb begin
		e03 = edge_fn(cx_q[0], cy_q[0], cx_q[3], cy_q[3], px_in, py_in);
		e32 = edge_fn(cx_q[3], cy_q[3], cx_q[2], cy_q[2], px_in, py_in);
		e20 = edge_fn(cx_q[2], cy_q[2], cx_q[0], cy_q[0], px_in, py_in);
		e21 = edge_fn(cx_q[2], cy_q[2], cx_q[1], cy_q[1], px_in, py_in);
		e10 = edge_fn(cx_q[1], cy_q[1], cx_q[0], cy_q[0], px_in, py_in);
		e02 = edge_fn(cx_q[0], cy_q[0], cx_q[2], cy_q[2], px_in, py_in);
		in1 = (e03 > 0 || (e03 == 0 && top_left(cx_q[0], cy_q[0], cx_q[3], cy_q[3])))
			&& (e32 > 0 || (e32 == 0 && top_left(cx_q[3], cy_q[3], cx_q[2], cy_q[2])))
			&& (e20 > 0 || (e20 == 0 && top_left(cx_q[2], cy_q[2], cx_q[0], cy_q[0])));
		in2 = (e21 > 0 || (e21 == 0 && top_left(cx_q[2], cy_q[2], cx_q[1], cy_q[1])))
			&& (e10 > 0 || (e10 == 0 && top_left(cx_q[1], cy_q[1], cx_q[0], cy_q[0])))
			&& (e02 > 0 || (e02 == 0 && top_left(cx_q[0], cy_q[0], cx_q[2], cy_q[2])));
		keep = !px_in[CoordW-1] && !py_in[CoordW-1] && px_in < maxx && py_in < maxy;
	end

	logic shade_s1, hit_s1, first_s1;
	edge_t ea_s1, eb_s1;
	logic [7:0] dx_s1, dy_s1;
	logic [TexAddrW-1:0] tidx_s1;
	logic [TexelW-1:0] tval_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_s1 <= 1'b0;
		else if (adv) v1_s1 <= in_acc;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			shade_s1 <= (op_in == OP_SHADE);
			hit_s1 <= keep && (in1 || in2);
			first_s1 <= in1;
			ea_s1 <= in1 ? e20 : e10;
			eb_s1 <= in1 ? e03 : e02;
			dx_s1 <= px_in[7:0];
			dy_s1 <= py_in[7:0];
			tidx_s1 <= tidx_in;
			tval_s1 <= tval_in;
		end
	end

	// stage 2: weights, u and v
	logic signed [MulW-1:0] wa, wb, u, v;
	assign wa = MulW'(ea_s1) * MulW'(first_s1 ? inv1 : inv2);
	assign wb = MulW'(eb_s1) * MulW'(first_s1 ? inv1 : inv2);
	assign u = first_s1 ? wb : wa + wb;
	assign v = first_s1 ? wa + wb : wa;

	logic shade_s2, hit_s2;
	logic signed [MulW-1:0] u_s2, v_s2;
	logic [7:0] dx_s2, dy_s2;
	logic [TexAddrW-1:0] tidx_s2;
	logic [TexelW-1:0] tval_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2_s2 <= 1'b0;
		else if (adv) v2_s2 <= v1_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			shade_s2 <= shade_s1;
			hit_s2 <= hit_s1;
			u_s2 <= u;
			v_s2 <= v;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			tidx_s2 <= tidx_s1;
			tval_s2 <= tval_s1;
		end
	end

	// texel coordinates: floor(w*size/2^16), range check
	localparam int TW = MulW + 9;
	logic signed [TW-1:0] tu, tv;
	logic okx, oky;
	logic [TexAddrW-1:0] taddr;
	always_comb begin
		tu = (TW'(u_s2) * TW'(TEX_W)) >>> FracBits;
		tv = (TW'(v_s2) * TW'(TEX_H)) >>> FracBits;
		okx = !u_s2[MulW-1] && tu < TW'(TEX_W);
		oky = !v_s2[MulW-1] && tv < TW'(TEX_H);
		taddr = TexAddrW'(tv * TW'(TEX_W) + tu);
	end

	// loads write as they leave stage 2, the same edge at which shades read,
	// so every shade sees exactly the loads that came before it
	logic [TexelW-1:0] rdata;
	logic we_ld;
	logic [TexAddrW-1:0] wa_ld;
	logic [TexelW-1:0] wd_ld;
	assign we_ld = adv && v2_s2 && !shade_s2;
	assign wa_ld = tidx_s2;
	assign wd_ld = tval_s2;

	tqps_ram #(.Width(TexelW), .Depth(TexDepth)) u_tex (.clk, .we(we_ld),
		.waddr(wa_ld), .wdata(wd_ld), .re(adv), .raddr(taddr), .rdata(rdata));

	logic draw_s3;
	logic [7:0] dx_s3, dy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3_s3 <= 1'b0;
		else if (adv) v3_s3 <= v2_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			draw_s3 <= shade_s2 && hit_s2 && okx && oky;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
		end
	end

	logic wr;
	assign wr = draw_s3 && rdata != '0;
	assign out_ch.data = {wr, wr ? dx_s3 : 8'd0, wr ? dy_s3 : 8'd0,
		wr ? rdata : TexelW'(0)};

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 && !out_ch.ready |=> v3_s3) else $error("result dropped");
	ap_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v2_s2 |=> v3_s3) else $error("stage lost");
	ap_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && wr |-> rdata != '0) else $error("zero color written");
endmodule

// ----- src/tqps_ram.sv -----
// generic single-write, single-read ram with registered read
module tqps_ram #(
	parameter int Width = 4,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// ----- src/tqps_inv_div.sv -----
// restoring divider: 2^16 / area, truncated, one quotient bit a cycle
module tqps_inv_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [tqps_pkg::AreaW-1:0] area,
	output logic signed [tqps_pkg::InvW-1:0]  inv,
	output tqps_pkg::div_status_t             status
);
	import tqps_pkg::*;

	localparam int NumW = FracBits + 1;
	logic [AreaW-1:0] den_q;
	logic [NumW-1:0]  num_q;
	logic [AreaW:0]   rem_q;
	logic [NumW-1:0]  quo_q;
	logic             neg_q, zero_q, busy_q, done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [AreaW:0]   rem_sh, rem_sub;

	assign rem_sh = {rem_q[AreaW-1:0], num_q[NumW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			inv <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DivCntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (done_q) begin
				if (zero_q) inv <= '0;
				else if (neg_q) inv <= -InvW'(quo_q);
				else inv <= InvW'(quo_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= area[AreaW-1];
			zero_q <= (area == '0);
			den_q <= area[AreaW-1] ? AreaW'(-area) : AreaW'(area);
			num_q <= NumW'(1) << FracBits;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!rem_sub[AreaW]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign status.busy = busy_q | start;
	assign status.done = done_q;

	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not start");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
	ap_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !done_q || cnt_q == '0) else $error("count out of step");
endmodule
